// ===== hdl/lane_line_select_and_steer_assert.svh =====
// -----------------------------------------------------------------------------
// lane_line_select_and_steer assertion macros
// Concurrent checks on clk, disabled while arst_n is low; empty in synthesis.
// -----------------------------------------------------------------------------
`ifndef LANE_LINE_SELECT_AND_STEER_ASSERT_SVH
`define LANE_LINE_SELECT_AND_STEER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LLSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define LLSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LLSS_ASSERT_NOW(label, ante, cons, msg)
`define LLSS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hdl/llss_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// llss_pkg
// Shared types and constants of the lane line select and steer block.
// -----------------------------------------------------------------------------
package llss_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_CENTER_X     = 3'd0,
		CFG_SLOPE_INV    = 3'd1,
		CFG_STEER_GAIN   = 3'd2,
		CFG_STEER_OFFSET = 3'd3,
		CFG_STEER_MIN    = 3'd4,
		CFG_STEER_MAX    = 3'd5
	} cfg_idx_t;

	// item kinds on the input tuser
	localparam logic CMD_SEG = 1'b0;
	localparam logic CMD_EOF = 1'b1;

	// reset values
	localparam int unsigned RST_CENTER_X   = 320;
	localparam int          CX_RST_BITS    = $clog2(RST_CENTER_X + 1);
	localparam logic [3:0]  RST_SLOPE_INV  = 4'd5;
	localparam logic [6:0]  RST_STEER_GAIN = 7'd35;
	localparam logic [7:0]  RST_STEER_OFS  = 8'd90;
	localparam logic [7:0]  RST_STEER_MIN  = 8'd20;
	localparam logic [7:0]  RST_STEER_MAX  = 8'd160;

	// gain is in hundredths
	localparam logic [6:0]  PCT_SCALE      = 7'd100;

	typedef struct packed {
		logic [6:0] gain;
		logic [7:0] offset;
		logic [7:0] lo;
		logic [7:0] hi;
	} steer_cfg_t;

	// select stage strobes
	typedef struct packed {
		logic seg_go;
		logic frame_go;
	} sel_ctl_t;

	// steering pipeline load enables
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic ld_s5;
	} pipe_ctl_t;

endpackage

// ===== hdl/llss_select.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// llss_select
// Keeps the longest left and right segment of a frame, folds them into the
// running averages at end of frame and forms the middle line.
// -----------------------------------------------------------------------------
module llss_select #(
	parameter int X_BITS = 10,
	parameter int Y_BITS = 9,
	localparam int CXW = (X_BITS > llss_pkg::CX_RST_BITS) ? X_BITS : llss_pkg::CX_RST_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  llss_pkg::sel_ctl_t ctl,
	input  logic [X_BITS-1:0] x1,
	input  logic [Y_BITS-1:0] y1,
	input  logic [X_BITS-1:0] x2,
	input  logic [Y_BITS-1:0] y2,
	input  logic [CXW-1:0]    center_x,
	input  logic [3:0]        slope_inv,
	output logic [X_BITS-1:0] mid_x1,
	output logic [Y_BITS-1:0] mid_y1,
	output logic [X_BITS-1:0] mid_x2,
	output logic [Y_BITS-1:0] mid_y2,
	output logic              no_left,
	output logic              no_right
);
	import llss_pkg::*;

	localparam int CW = (X_BITS + 2 > Y_BITS + 6) ? X_BITS + 2 : Y_BITS + 6;
	localparam int LW = 2 * ((X_BITS > Y_BITS) ? X_BITS : Y_BITS) + 1;

	logic [X_BITS-1:0] bl_x1_q, bl_x2_q, br_x1_q, br_x2_q;
	logic [Y_BITS-1:0] bl_y1_q, bl_y2_q, br_y1_q, br_y2_q;
	logic [LW-1:0]     bl_len_q, br_len_q;
	logic [X_BITS-1:0] la_x1_q, la_x2_q, ra_x1_q, ra_x2_q;
	logic [Y_BITS-1:0] la_y1_q, la_y2_q, ra_y1_q, ra_y2_q;
	logic              l_seen_q, r_seen_q;

	logic signed [X_BITS:0]   dx;
	logic signed [Y_BITS:0]   dy;
	logic signed [Y_BITS+5:0] dyk;
	logic signed [CW-1:0]     dx_c, ndx_c, dyk_c;
	logic [X_BITS-1:0]        adx;
	logic [Y_BITS-1:0]        ady;
	logic [2*X_BITS-1:0]      sqx;
	logic [2*Y_BITS-1:0]      sqy;
	logic [LW-1:0]            len;
	logic                     is_left, is_right, take_l, take_r;

	logic [X_BITS-1:0] nla_x1, nla_x2, nra_x1, nra_x2;
	logic [Y_BITS-1:0] nla_y1, nla_y2, nra_y1, nra_y2;
	logic [X_BITS:0]   sum_mx1, sum_mx2;
	logic [Y_BITS:0]   sum_my1, sum_my2;

	// slope test, cross-multiplied
	assign dx    = $signed({1'b0, x2}) - $signed({1'b0, x1});
	assign dy    = $signed({1'b0, y2}) - $signed({1'b0, y1});
	assign dyk   = $signed((Y_BITS + 6)'(dy)) * $signed((Y_BITS + 6)'({1'b0, slope_inv}));
	assign dx_c  = CW'(dx);
	assign ndx_c = -dx_c;
	assign dyk_c = CW'(dyk);

	always_comb begin
		if (dx > 0) begin
			is_left  = dyk_c < ndx_c;
			is_right = dyk_c > dx_c;
		end else if (dx < 0) begin
			is_left  = dyk_c > ndx_c;
			is_right = dyk_c < dx_c;
		end else begin
			is_left  = dy < 0;
			is_right = dy > 0;
		end
	end

	// squared length
	assign adx = dx[X_BITS] ? X_BITS'(-dx) : X_BITS'(dx);
	assign ady = dy[Y_BITS] ? Y_BITS'(-dy) : Y_BITS'(dy);
	assign sqx = (2 * X_BITS)'(adx) * (2 * X_BITS)'(adx);
	assign sqy = (2 * Y_BITS)'(ady) * (2 * Y_BITS)'(ady);
	assign len = LW'(sqx) + LW'(sqy);

	assign take_l = is_left && (CXW'(x1) < center_x) && (CXW'(x2) < center_x)
		&& (bl_len_q < len);
	assign take_r = is_right && (CXW'(x1) > center_x) && (CXW'(x2) > center_x)
		&& (br_len_q < len);

	// end of frame: fold kept lines into the averages
	assign no_left  = (bl_len_q == '0);
	assign no_right = (br_len_q == '0);

	always_comb begin
		nla_x1 = la_x1_q;
		nla_y1 = la_y1_q;
		nla_x2 = la_x2_q;
		nla_y2 = la_y2_q;
		nra_x1 = ra_x1_q;
		nra_y1 = ra_y1_q;
		nra_x2 = ra_x2_q;
		nra_y2 = ra_y2_q;
		if (!no_left) begin
			nla_x1 = l_seen_q ? X_BITS'(({1'b0, la_x1_q} + {1'b0, bl_x1_q}) >> 1) : bl_x1_q;
			nla_y1 = l_seen_q ? Y_BITS'(({1'b0, la_y1_q} + {1'b0, bl_y1_q}) >> 1) : bl_y1_q;
			nla_x2 = l_seen_q ? X_BITS'(({1'b0, la_x2_q} + {1'b0, bl_x2_q}) >> 1) : bl_x2_q;
			nla_y2 = l_seen_q ? Y_BITS'(({1'b0, la_y2_q} + {1'b0, bl_y2_q}) >> 1) : bl_y2_q;
		end
		if (!no_right) begin
			nra_x1 = r_seen_q ? X_BITS'(({1'b0, ra_x1_q} + {1'b0, br_x1_q}) >> 1) : br_x1_q;
			nra_y1 = r_seen_q ? Y_BITS'(({1'b0, ra_y1_q} + {1'b0, br_y1_q}) >> 1) : br_y1_q;
			nra_x2 = r_seen_q ? X_BITS'(({1'b0, ra_x2_q} + {1'b0, br_x2_q}) >> 1) : br_x2_q;
			nra_y2 = r_seen_q ? Y_BITS'(({1'b0, ra_y2_q} + {1'b0, br_y2_q}) >> 1) : br_y2_q;
		end
	end

	// middle line pairs the left start with the right end
	assign sum_mx1 = {1'b0, nla_x1} + {1'b0, nra_x2};
	assign sum_my1 = {1'b0, nla_y1} + {1'b0, nra_y2};
	assign sum_mx2 = {1'b0, nla_x2} + {1'b0, nra_x1};
	assign sum_my2 = {1'b0, nla_y2} + {1'b0, nra_y1};
	assign mid_x1  = sum_mx1[X_BITS:1];
	assign mid_y1  = sum_my1[Y_BITS:1];
	assign mid_x2  = sum_mx2[X_BITS:1];
	assign mid_y2  = sum_my2[Y_BITS:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bl_x1_q  <= '0;
			bl_y1_q  <= '0;
			bl_x2_q  <= '0;
			bl_y2_q  <= '0;
			br_x1_q  <= '0;
			br_y1_q  <= '0;
			br_x2_q  <= '0;
			br_y2_q  <= '0;
			bl_len_q <= '0;
			br_len_q <= '0;
			la_x1_q  <= '0;
			la_y1_q  <= '0;
			la_x2_q  <= '0;
			la_y2_q  <= '0;
			ra_x1_q  <= '0;
			ra_y1_q  <= '0;
			ra_x2_q  <= '0;
			ra_y2_q  <= '0;
			l_seen_q <= 1'b0;
			r_seen_q <= 1'b0;
		end else if (ctl.frame_go) begin
			la_x1_q  <= nla_x1;
			la_y1_q  <= nla_y1;
			la_x2_q  <= nla_x2;
			la_y2_q  <= nla_y2;
			ra_x1_q  <= nra_x1;
			ra_y1_q  <= nra_y1;
			ra_x2_q  <= nra_x2;
			ra_y2_q  <= nra_y2;
			l_seen_q <= l_seen_q || !no_left;
			r_seen_q <= r_seen_q || !no_right;
			// drop the per-frame bests
			bl_x1_q  <= '0;
			bl_y1_q  <= '0;
			bl_x2_q  <= '0;
			bl_y2_q  <= '0;
			br_x1_q  <= '0;
			br_y1_q  <= '0;
			br_x2_q  <= '0;
			br_y2_q  <= '0;
			bl_len_q <= '0;
			br_len_q <= '0;
		end else if (ctl.seg_go) begin
			if (take_l) begin
				bl_x1_q  <= x1;
				bl_y1_q  <= y1;
				bl_x2_q  <= x2;
				bl_y2_q  <= y2;
				bl_len_q <= len;
			end
			if (take_r) begin
				br_x1_q  <= x1;
				br_y1_q  <= y1;
				br_x2_q  <= x2;
				br_y2_q  <= y2;
				br_len_q <= len;
			end
		end
	end

`include "lane_line_select_and_steer_assert.svh"

	`LLSS_ASSERT_NEXT(a_frame_clears_best, ctl.frame_go, (bl_len_q == '0) && (br_len_q == '0), "per-frame bests not cleared at end of frame")
	`LLSS_ASSERT_NEXT(a_best_grows, ctl.seg_go && !ctl.frame_go, (bl_len_q >= $past(bl_len_q)) && (br_len_q >= $past(br_len_q)), "kept length shrank on a segment")

endmodule

// ===== hdl/llss_steer.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// llss_steer
// Steering angle: center offset times gain plus 100 times offset, divided by one
// hundred by reciprocal multiply and one correction step, clamp, output register.
// -----------------------------------------------------------------------------
module llss_steer #(
	parameter int X_BITS = 10,
	parameter int Y_BITS = 9,
	localparam int CXW = (X_BITS > llss_pkg::CX_RST_BITS) ? X_BITS : llss_pkg::CX_RST_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  llss_pkg::pipe_ctl_t  ctl,
	input  llss_pkg::steer_cfg_t cfg,
	input  logic [CXW-1:0]       center_x,
	input  logic [X_BITS-1:0]    mid_x1,
	input  logic [Y_BITS-1:0]    mid_y1,
	input  logic [X_BITS-1:0]    mid_x2,
	input  logic [Y_BITS-1:0]    mid_y2,
	input  logic                 no_left,
	input  logic                 no_right,
	output logic [7:0]           angle_s5,
	output logic                 no_left_s5,
	output logic                 no_right_s5,
	output logic [X_BITS-1:0]    mid_x1_s5,
	output logic [Y_BITS-1:0]    mid_y1_s5,
	output logic [X_BITS-1:0]    mid_x2_s5,
	output logic [Y_BITS-1:0]    mid_y2_s5
);
	import llss_pkg::*;

	localparam int OW = CXW + 1;                   // signed center offset
	localparam int PW = OW + 8;                    // offset times gain
	localparam int BW = 16;                        // offset*100 plus sign
	localparam int NW = ((PW > BW) ? PW : BW) + 1; // numerator
	localparam int SH = NW + 7;
	localparam int QW = NW - 6;
	localparam logic [NW:0] RECIP = (NW + 1)'((64'd1 << SH) / 64'd100);

	logic [X_BITS-1:0] mid_x1_s2, mid_x2_s2, mid_x1_s3, mid_x2_s3, mid_x1_s4, mid_x2_s4;
	logic [Y_BITS-1:0] mid_y1_s2, mid_y2_s2, mid_y1_s3, mid_y2_s3, mid_y1_s4, mid_y2_s4;
	logic              nl_s2, nr_s2, nl_s3, nr_s3, nl_s4, nr_s4;
	logic [NW-1:0]     nabs_s3, nabs_s4;
	logic              neg_s3, neg_s4;
	logic [QW-1:0]     q0_s4;

	logic [X_BITS:0]        msum;
	logic [X_BITS-1:0]      mavg;
	logic signed [OW-1:0]   ofs;
	logic signed [PW-1:0]   prod;
	logic [14:0]            base;
	logic signed [NW-1:0]   num;
	logic                   neg;
	logic [NW-1:0]          nabs;
	logic [2*NW:0]          rprod;
	logic [QW-1:0]          q0;
	logic [NW:0]            qm, rem;
	logic [QW:0]            q;
	logic signed [QW+1:0]   ang, lo_ext, hi_ext, ang_lo, ang_hi;

	// stage 2: offset and scaled numerator
	assign msum = {1'b0, mid_x1_s2} + {1'b0, mid_x2_s2};
	assign mavg = msum[X_BITS:1];
	assign ofs  = $signed(OW'(mavg)) - $signed(OW'(center_x));
	assign prod = $signed(PW'(ofs)) * $signed(PW'({1'b0, cfg.gain}));
	assign base = 15'(cfg.offset) * 15'(PCT_SCALE);
	assign num  = $signed(NW'(prod)) + $signed(NW'(base));
	assign neg  = num[NW-1];
	assign nabs = neg ? NW'(-num) : NW'(num);

	// stage 3: quotient estimate, low by at most one
	assign rprod = (2 * NW + 1)'(nabs_s3) * (2 * NW + 1)'(RECIP);
	assign q0    = rprod[2*NW:SH];

	// stage 4: correct, restore sign, clamp (ceiling wins)
	assign qm     = (NW + 1)'(q0_s4) * (NW + 1)'(PCT_SCALE);
	assign rem    = {1'b0, nabs_s4} - qm;
	assign q      = {1'b0, q0_s4} + (QW + 1)'(rem >= (NW + 1)'(PCT_SCALE));
	assign ang    = neg_s4 ? -$signed({1'b0, q}) : $signed({1'b0, q});
	assign lo_ext = $signed((QW + 2)'(cfg.lo));
	assign hi_ext = $signed((QW + 2)'(cfg.hi));
	assign ang_lo = (ang < lo_ext) ? lo_ext : ang;
	assign ang_hi = (ang_lo > hi_ext) ? hi_ext : ang_lo;

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			mid_x1_s2 <= mid_x1;
			mid_y1_s2 <= mid_y1;
			mid_x2_s2 <= mid_x2;
			mid_y2_s2 <= mid_y2;
			nl_s2     <= no_left;
			nr_s2     <= no_right;
		end
		if (ctl.ld_s3) begin
			mid_x1_s3 <= mid_x1_s2;
			mid_y1_s3 <= mid_y1_s2;
			mid_x2_s3 <= mid_x2_s2;
			mid_y2_s3 <= mid_y2_s2;
			nl_s3     <= nl_s2;
			nr_s3     <= nr_s2;
			nabs_s3   <= nabs;
			neg_s3    <= neg;
		end
		if (ctl.ld_s4) begin
			mid_x1_s4 <= mid_x1_s3;
			mid_y1_s4 <= mid_y1_s3;
			mid_x2_s4 <= mid_x2_s3;
			mid_y2_s4 <= mid_y2_s3;
			nl_s4     <= nl_s3;
			nr_s4     <= nr_s3;
			nabs_s4   <= nabs_s3;
			neg_s4    <= neg_s3;
			q0_s4     <= q0;
		end
		if (ctl.ld_s5) begin
			mid_x1_s5   <= mid_x1_s4;
			mid_y1_s5   <= mid_y1_s4;
			mid_x2_s5   <= mid_x2_s4;
			mid_y2_s5   <= mid_y2_s4;
			no_left_s5  <= nl_s4;
			no_right_s5 <= nr_s4;
			angle_s5    <= ang_hi[7:0];
		end
	end

`include "lane_line_select_and_steer_assert.svh"

	`LLSS_ASSERT_NEXT(a_angle_in_range, ctl.ld_s5 && (cfg.lo <= cfg.hi), (angle_s5 >= cfg.lo) && (angle_s5 <= cfg.hi), "steering angle outside clamp range")

endmodule

// ===== hdl/lane_line_select_and_steer.sv =====
`timescale 1ns / 1ps
// Throughput: one beat per cycle on s_axis, segments and end-of-frame alike, while
// no end-of-frame beat waits on full steering stages. A segment updates the kept
// lines from the input register; an end-of-frame result passes three steering
// stages and the output register, which let new beats in while a result waits.
// Reset clears configuration to defaults and all lane state.
// -----------------------------------------------------------------------------
// lane_line_select_and_steer
// Lane line selection from Hough segments and clamped steering angle output.
// -----------------------------------------------------------------------------
module lane_line_select_and_steer #(
	parameter int X_BITS = 10,
	parameter int Y_BITS = 9,
	localparam int IW = ((2 * X_BITS + 2 * Y_BITS + 7) / 8) * 8,
	localparam int RW = ((10 + 2 * X_BITS + 2 * Y_BITS + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_idx,
	input  logic [X_BITS-1:0] cfg_data,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [IW-1:0]     s_axis_tdata,  // seg_x1, seg_y1, seg_x2, seg_y2, zero pad
	input  logic              s_axis_tuser,  // cmd
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [RW-1:0]     m_axis_tdata   // steer_angle, no_left, no_right,
	                                         // mid_x1, mid_y1, mid_x2, mid_y2, zero pad
);
	import llss_pkg::*;

	localparam int CXW = (X_BITS > CX_RST_BITS) ? X_BITS : CX_RST_BITS;
	localparam int SW  = 2 * X_BITS + 2 * Y_BITS;

	logic [CXW-1:0] center_x_q;
	logic [3:0]     slope_inv_q;
	steer_cfg_t     steer_q;

	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic              cmd_s1;
	logic [X_BITS-1:0] x1_s1, x2_s1;
	logic [Y_BITS-1:0] y1_s1, y2_s1;
	logic              rdy2, rdy3, rdy4, rdy5, go1, in_acc;
	sel_ctl_t          sctl;
	pipe_ctl_t         pctl;

	logic [X_BITS-1:0] mid_x1, mid_x2, o_x1, o_x2;
	logic [Y_BITS-1:0] mid_y1, mid_y2, o_y1, o_y2;
	logic              no_left, no_right, o_nl, o_nr;
	logic [7:0]        o_angle;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q    <= CXW'(RST_CENTER_X);
			slope_inv_q   <= RST_SLOPE_INV;
			steer_q.gain   <= RST_STEER_GAIN;
			steer_q.offset <= RST_STEER_OFS;
			steer_q.lo     <= RST_STEER_MIN;
			steer_q.hi     <= RST_STEER_MAX;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_CENTER_X:     center_x_q     <= CXW'(cfg_data);
				CFG_SLOPE_INV:    slope_inv_q    <= cfg_data[3:0];
				CFG_STEER_GAIN:   steer_q.gain   <= cfg_data[6:0];
				CFG_STEER_OFFSET: steer_q.offset <= cfg_data[7:0];
				CFG_STEER_MIN:    steer_q.lo     <= cfg_data[7:0];
				CFG_STEER_MAX:    steer_q.hi     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// flow control: a segment retires in stage 1, a frame end moves on
	assign rdy5 = !v_s5 || m_axis_tready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign go1  = v_s1 && ((cmd_s1 == CMD_SEG) || rdy2);

	assign s_axis_tready = !v_s1 || go1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign sctl.seg_go   = go1 && (cmd_s1 == CMD_SEG);
	assign sctl.frame_go = go1 && (cmd_s1 == CMD_EOF);
	assign pctl.ld_s2    = sctl.frame_go;
	assign pctl.ld_s3    = v_s2 && rdy3;
	assign pctl.ld_s4    = v_s3 && rdy4;
	assign pctl.ld_s5    = v_s4 && rdy5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_acc || (v_s1 && !go1);
			v_s2 <= pctl.ld_s2 || (v_s2 && !pctl.ld_s3);
			v_s3 <= pctl.ld_s3 || (v_s3 && !pctl.ld_s4);
			v_s4 <= pctl.ld_s4 || (v_s4 && !pctl.ld_s5);
			v_s5 <= pctl.ld_s5 || (v_s5 && !m_axis_tready);
		end
	end

	// input register: hold the beat until stage 1 retires it
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1 <= s_axis_tuser;
			x1_s1  <= s_axis_tdata[X_BITS-1:0];
			y1_s1  <= s_axis_tdata[X_BITS+Y_BITS-1:X_BITS];
			x2_s1  <= s_axis_tdata[2*X_BITS+Y_BITS-1:X_BITS+Y_BITS];
			y2_s1  <= s_axis_tdata[SW-1:2*X_BITS+Y_BITS];
		end
	end

	llss_select #(
		.X_BITS(X_BITS),
		.Y_BITS(Y_BITS)
	) u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (sctl),
		.x1       (x1_s1),
		.y1       (y1_s1),
		.x2       (x2_s1),
		.y2       (y2_s1),
		.center_x (center_x_q),
		.slope_inv(slope_inv_q),
		.mid_x1   (mid_x1),
		.mid_y1   (mid_y1),
		.mid_x2   (mid_x2),
		.mid_y2   (mid_y2),
		.no_left  (no_left),
		.no_right (no_right)
	);

	llss_steer #(
		.X_BITS(X_BITS),
		.Y_BITS(Y_BITS)
	) u_steer (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (pctl),
		.cfg        (steer_q),
		.center_x   (center_x_q),
		.mid_x1     (mid_x1),
		.mid_y1     (mid_y1),
		.mid_x2     (mid_x2),
		.mid_y2     (mid_y2),
		.no_left    (no_left),
		.no_right   (no_right),
		.angle_s5   (o_angle),
		.no_left_s5 (o_nl),
		.no_right_s5(o_nr),
		.mid_x1_s5  (o_x1),
		.mid_y1_s5  (o_y1),
		.mid_x2_s5  (o_x2),
		.mid_y2_s5  (o_y2)
	);

	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = RW'({o_y2, o_x2, o_y1, o_x1, o_nr, o_nl, o_angle});

`include "lane_line_select_and_steer_assert.svh"

	`LLSS_ASSERT_NEXT(a_frame_enters_s2, pctl.ld_s2, v_s2, "end-of-frame beat lost on its way to the steering stages")
	`LLSS_ASSERT_NOW(a_empty_takes_beat, !v_s1, s_axis_tready, "empty input stage refused a beat")

endmodule
